>>> hw/rtl/mf3_pkg.sv
`default_nettype none

package mf3_pkg;

   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int CHANNEL_BITS_DEF = 8;
   localparam int MAX_HEIGHT       = 1024;
   localparam int MIN_SIZE         = 3;
   localparam int CFG_BITS         = 11;
   localparam int ROW_BITS         = 11;
   localparam int WIDTH_RESET      = 640;
   localparam int HEIGHT_RESET     = 480;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic drop;
      logic pixel;
      logic has_out;
      logic interior;
      logic frame_end;
   } pos_info_type;

endpackage

`default_nettype wire

>>> hw/rtl/mf3_req_if.sv
`default_nettype none

interface mf3_req_if import mf3_pkg::*; #(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic                    is_flush;
   logic [CHANNEL_BITS-1:0] in_blue;
   logic [CHANNEL_BITS-1:0] in_green;
   logic [CHANNEL_BITS-1:0] in_red;

   modport source (output valid, is_flush, in_blue, in_green, in_red, input ready);
   modport sink (input valid, is_flush, in_blue, in_green, in_red, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mf3_rsp_if.sv
`default_nettype none

interface mf3_rsp_if import mf3_pkg::*; #(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] out_blue;
   logic [CHANNEL_BITS-1:0] out_green;
   logic [CHANNEL_BITS-1:0] out_red;
   logic                    frame_end;

   modport source (output valid, out_blue, out_green, out_red, frame_end, input ready);
   modport sink (input valid, out_blue, out_green, out_red, frame_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mf3_ram.sv
`default_nettype none

module mf3_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mf3_lane.sv
`default_nettype none

module mf3_lane import mf3_pkg::*; #(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    shift,
   input  logic [CHANNEL_BITS-1:0] new_top,
   input  logic [CHANNEL_BITS-1:0] new_mid,
   input  logic [CHANNEL_BITS-1:0] new_bot,
   output logic [CHANNEL_BITS-1:0] max_val,
   output logic [CHANNEL_BITS-1:0] centre
);

   logic [2:0][CHANNEL_BITS-1:0] col1_ff;
   logic [2:0][CHANNEL_BITS-1:0] col2_ff;
   logic [2:0][CHANNEL_BITS-1:0] col1_in;
   logic [2:0][CHANNEL_BITS-1:0] col2_in;
   logic [CHANNEL_BITS-1:0]      max_a;
   logic [CHANNEL_BITS-1:0]      max_b;
   logic [CHANNEL_BITS-1:0]      max_c;

   function automatic logic [CHANNEL_BITS-1:0] max2(
      input logic [CHANNEL_BITS-1:0] a,
      input logic [CHANNEL_BITS-1:0] b
   );
      max2 = (a > b) ? a : b;
   endfunction

   // window after the shift: old second column, old newest column, incoming column
   always_comb begin
      max_a   = max2(max2(col1_ff[0], col1_ff[1]), col1_ff[2]);
      max_b   = max2(max2(col2_ff[0], col2_ff[1]), col2_ff[2]);
      max_c   = max2(max2(new_top, new_mid), new_bot);
      max_val = max2(max2(max_a, max_b), max_c);
      centre  = col2_ff[1];
      col1_in = col2_ff;
      col2_in = {new_bot, new_mid, new_top};
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         col1_ff <= col1_in;
         col2_ff <= col2_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/mf3_pos.sv
`default_nettype none

module mf3_pos import mf3_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  csr_idx_type                  csr_index,
   input  logic [CFG_BITS-1:0]          csr_wdata,
   input  logic                         accept,
   input  logic                         is_flush,
   output logic [$clog2(MAX_WIDTH)-1:0] col,
   output pos_info_type                 info
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int WW       = $clog2(MAX_WIDTH + 1);
   localparam int WCALC    = (CFG_BITS > WW) ? CFG_BITS : WW;
   localparam int W_RESET  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

   logic [WW-1:0]       width_ff;
   logic [WW-1:0]       width_in;
   logic [CFG_BITS-1:0] height_ff;
   logic [CFG_BITS-1:0] height_in;
   logic [COL_BITS-1:0] col_ff;
   logic [COL_BITS-1:0] col_in;
   logic [ROW_BITS-1:0] row_ff;
   logic [ROW_BITS-1:0] row_in;
   logic [WCALC-1:0]    wdata_ext;
   logic [WW-1:0]       width_clamped;
   logic [CFG_BITS-1:0] height_clamped;
   logic                col_last;
   logic                in_frame;

   always_comb begin
      wdata_ext = WCALC'(csr_wdata);
      if (wdata_ext < WCALC'(MIN_SIZE)) begin
         width_clamped = WW'(MIN_SIZE);
      end else if (wdata_ext > WCALC'(MAX_WIDTH)) begin
         width_clamped = WW'(MAX_WIDTH);
      end else begin
         width_clamped = WW'(wdata_ext);
      end
      if (csr_wdata < CFG_BITS'(MIN_SIZE)) begin
         height_clamped = CFG_BITS'(MIN_SIZE);
      end else if (csr_wdata > CFG_BITS'(MAX_HEIGHT)) begin
         height_clamped = CFG_BITS'(MAX_HEIGHT);
      end else begin
         height_clamped = csr_wdata;
      end
   end

   always_comb begin
      col_last       = (WW'(col_ff) == (width_ff - WW'(1)));
      in_frame       = (row_ff < ROW_BITS'(height_ff));
      info.pixel     = in_frame;
      info.drop      = in_frame && is_flush;
      info.has_out   = !((row_ff == '0) || ((row_ff == ROW_BITS'(1)) && (col_ff == '0)));
      info.interior  = (col_ff >= COL_BITS'(2)) && (row_ff >= ROW_BITS'(2)) && in_frame;
      info.frame_end = (col_ff == '0) &&
                       (row_ff == (ROW_BITS'(height_ff) + ROW_BITS'(1)));
      col            = col_ff;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = width_clamped;
            CSR_HEIGHT: height_in = height_clamped;
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept && !info.drop) begin
         if (info.frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_last) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(W_RESET);
         height_ff <= CFG_BITS'(HEIGHT_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   a_interior_has_out: assert property (@(posedge clock) disable iff (reset)
      info.interior |-> info.has_out)
      else $error("interior position without a result");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && !info.drop && info.frame_end && !csr_we) |=> (col_ff == '0 && row_ff == '0))
      else $error("position not restarted after frame end");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (WW'(col_ff) < width_ff))
      else $error("column beyond row width");

endmodule

`default_nettype wire

>>> hw/rtl/max_filter_3x3_rgb_unit.sv
// Pipeline: a beat is registered in the first stage with its line-store read, then its
// result in the output register; results trail the input stream by image_width + 1 beats.
// Throughput: 1 beat per cycle when the output is not stalled; one store read and write.
// Reset: frame position and valids clear, width 640 and height 480; line store and
// window hold stale data that is always overwritten before it reaches an interior result.
`default_nettype none

module max_filter_3x3_rgb_unit import mf3_pkg::*; #(
   parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   mf3_req_if.sink             req_bus,
   mf3_rsp_if.source           rsp_bus,
   input  logic                csr_we,
   input  csr_idx_type         csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int PIX_BITS = 3 * CHANNEL_BITS;

   logic                      accept;
   pos_info_type              info;
   logic [COL_BITS-1:0]       col;
   logic [PIX_BITS-1:0]       px_in;
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   pos_info_type              s1_info_ff;
   logic [COL_BITS-1:0]       s1_col_ff;
   logic [PIX_BITS-1:0]       s1_px_ff;
   logic                      s1_load;
   logic                      out_free;
   logic                      adv1;
   logic                      rsp_load;
   logic [2*PIX_BITS-1:0]     ram_q;
   logic [2:0][CHANNEL_BITS-1:0] lane_max;
   logic [2:0][CHANNEL_BITS-1:0] lane_centre;
   logic [2:0][CHANNEL_BITS-1:0] out_px_in;
   logic [2:0][CHANNEL_BITS-1:0] out_px_ff;
   logic                      frame_end_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   mf3_pos #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .is_flush  (req_bus.is_flush),
      .col       (col),
      .info      (info)
   );

   always_comb begin
      out_free       = !rsp_valid_ff || rsp_bus.ready;
      adv1           = s1_valid_ff && (!s1_info_ff.has_out || out_free);
      req_bus.ready  = !s1_valid_ff || adv1;
      accept         = req_bus.valid && req_bus.ready;
      s1_load        = accept && !info.drop;
      rsp_load       = adv1 && s1_info_ff.has_out;
      // drain beats enter the window as zero
      px_in          = info.pixel ? {req_bus.in_red, req_bus.in_green, req_bus.in_blue}
                                  : '0;
      s1_valid_in    = s1_load ? 1'b1 : (adv1 ? 1'b0 : s1_valid_ff);
      rsp_valid_in   = rsp_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   // entry: upper row in the high half, middle row in the low half
   mf3_ram #(
      .WIDTH (2 * PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (adv1),
      .waddr (s1_col_ff),
      .wdata ({ram_q[PIX_BITS-1:0], s1_px_ff}),
      .re    (s1_load),
      .raddr (col),
      .rdata (ram_q)
   );

   for (genvar c = 0; c < 3; c++) begin : g_lane
      mf3_lane #(
         .CHANNEL_BITS (CHANNEL_BITS)
      ) u_lane (
         .clock   (clock),
         .shift   (adv1),
         .new_top (ram_q[PIX_BITS + c*CHANNEL_BITS +: CHANNEL_BITS]),
         .new_mid (ram_q[c*CHANNEL_BITS +: CHANNEL_BITS]),
         .new_bot (s1_px_ff[c*CHANNEL_BITS +: CHANNEL_BITS]),
         .max_val (lane_max[c]),
         .centre  (lane_centre[c])
      );
      assign out_px_in[c] = s1_info_ff.interior ? lane_max[c] : lane_centre[c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_info_ff <= info;
         s1_col_ff  <= col;
         s1_px_ff   <= px_in;
      end
      if (rsp_load) begin
         out_px_ff    <= out_px_in;
         frame_end_ff <= s1_info_ff.frame_end;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_blue  = out_px_ff[0];
   assign rsp_bus.out_green = out_px_ff[1];
   assign rsp_bus.out_red   = out_px_ff[2];
   assign rsp_bus.frame_end = frame_end_ff;

   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_info_ff.has_out && rsp_valid_ff && !rsp_bus.ready)
      |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("pending beat lost while result is blocked");

   a_no_accept_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_info_ff.has_out && rsp_valid_ff && !rsp_bus.ready)
      |-> !req_bus.ready)
      else $error("beat taken while first stage is blocked");

   a_load_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten");

endmodule

`default_nettype wire
